>>> rtl/csvs_pkg.sv
// Shared types and constants for the CSV line field splitter.
package csvs_pkg;

    // Character codes that the parser reacts to.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Default column capacity and the reset value of the field limit register.
    localparam int unsigned MAX_COLUMNS_DEF = 128;
    localparam logic [7:0]  LIMIT_CFG_RESET = 8'd128;

    // Width used for limit compares: holds any limit register value and any capacity up to 256.
    localparam int unsigned LIM_W = 9;

    // Field index width on the result port.
    localparam int unsigned IDX_W = 7;

    // Depth of the queue between the parser and the output stage.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // One result item as it travels from the parser to the output.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             data_valid;
        logic             field_end;
        logic [IDX_W-1:0] field_index;
        logic             line_end;
        logic             truncated;
    } res_t;

endpackage

>>> rtl/csvs_front.sv
// Parser front end: accepts bytes, tracks quoting and field count, builds one result each.
module csvs_front #(
    parameter int unsigned MAX_COLUMNS = csvs_pkg::MAX_COLUMNS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     char_in,
    input  logic           is_end,
    input  logic           q_full,
    output logic           q_push,
    output csvs_pkg::res_t q_data
);

    localparam int unsigned FW = $clog2(MAX_COLUMNS + 1);
    localparam logic [csvs_pkg::LIM_W-1:0] CAP = csvs_pkg::LIM_W'(MAX_COLUMNS);

    typedef enum logic [1:0] {
        MODE_UNQ  = 2'd0,
        MODE_QUO  = 2'd1,
        MODE_SEEN = 2'd2
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic                start_reg, start_next;
    logic [FW-1:0]       field_reg, field_next;
    logic [7:0]          limit_cfg_reg;

    logic [csvs_pkg::LIM_W-1:0] lim;
    logic [csvs_pkg::LIM_W-1:0] field_w;
    logic [csvs_pkg::IDX_W-1:0] idx;
    logic                       over;
    logic                       unq_path;
    csvs_pkg::res_t             res;

    // A request is taken whenever the queue has room.
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign q_data   = res;

    // Effective limit: zero acts as one, values above capacity clamp to capacity.
    always_comb
    begin
        if (limit_cfg_reg == 8'd0)
            lim = csvs_pkg::LIM_W'(1);
        else if (csvs_pkg::LIM_W'(limit_cfg_reg) > CAP)
            lim = CAP;
        else
            lim = csvs_pkg::LIM_W'(limit_cfg_reg);
    end

    assign field_w = csvs_pkg::LIM_W'(field_reg);
    assign idx     = field_w[csvs_pkg::IDX_W-1:0];
    assign over    = (field_w >= lim);

    // Byte classification and next-state logic.
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        field_next = field_reg;
        unq_path   = 1'b0;
        res        = '0;

        if (is_end)
        begin
            res.line_end = 1'b1;
            if (!over)
            begin
                res.field_end   = 1'b1;
                res.field_index = idx;
            end
            else
            begin
                res.truncated = 1'b1;
            end
            mode_next  = MODE_UNQ;
            start_next = 1'b1;
            field_next = '0;
        end
        else if (char_in == csvs_pkg::CH_CR || char_in == csvs_pkg::CH_LF)
        begin
            // Line terminators are dropped with no state change.
        end
        else if (over)
        begin
            res.truncated = 1'b1;
        end
        else if (mode_reg == MODE_QUO)
        begin
            if (char_in == csvs_pkg::CH_QUOTE)
            begin
                mode_next = MODE_SEEN;
            end
            else
            begin
                start_next      = 1'b0;
                res.data_byte   = char_in;
                res.data_valid  = 1'b1;
                res.field_index = idx;
            end
        end
        else if (mode_reg == MODE_SEEN && char_in == csvs_pkg::CH_QUOTE)
        begin
            // Doubled quote inside quotes yields one literal quote.
            mode_next       = MODE_QUO;
            start_next      = 1'b0;
            res.data_byte   = csvs_pkg::CH_QUOTE;
            res.data_valid  = 1'b1;
            res.field_index = idx;
        end
        else
        begin
            unq_path  = 1'b1;
            mode_next = MODE_UNQ;
        end

        // Unquoted handling, also reached after a pending closing quote.
        if (unq_path)
        begin
            if (char_in == csvs_pkg::CH_QUOTE)
            begin
                mode_next = MODE_QUO;
                if (start_reg)
                begin
                    start_next = 1'b0;
                end
                else
                begin
                    res.data_byte   = csvs_pkg::CH_QUOTE;
                    res.data_valid  = 1'b1;
                    res.field_index = idx;
                end
            end
            else if (char_in == csvs_pkg::CH_COMMA)
            begin
                res.field_end   = 1'b1;
                res.field_index = idx;
                field_next      = field_reg + FW'(1);
                start_next      = 1'b1;
            end
            else
            begin
                start_next      = 1'b0;
                res.data_byte   = char_in;
                res.data_valid  = 1'b1;
                res.field_index = idx;
            end
        end
    end

    // Parser state and the field limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_UNQ;
            start_reg     <= 1'b1;
            field_reg     <= '0;
            limit_cfg_reg <= csvs_pkg::LIMIT_CFG_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                limit_cfg_reg <= cfg_wr_data;
            if (q_push)
            begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                field_reg <= field_next;
            end
        end
    end

endmodule

>>> rtl/csvs_fifo.sv
// Short result queue between the parser and the output stage.
module csvs_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  csvs_pkg::res_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output csvs_pkg::res_t pop_data
);

    csvs_pkg::res_t                mem_reg [csvs_pkg::QDEPTH];
    logic [csvs_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [csvs_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [csvs_pkg::QCNT_W-1:0]   count_reg;

    assign full     = (count_reg == csvs_pkg::QCNT_W'(csvs_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + csvs_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + csvs_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + csvs_pkg::QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - csvs_pkg::QCNT_W'(1);
        end
    end

endmodule

>>> rtl/csvs_back.sv
// Output stage: moves results from the queue into the output register.
module csvs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  csvs_pkg::res_t q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output csvs_pkg::res_t out_res
);

    logic           valid_reg;
    csvs_pkg::res_t res_reg;

    // Load a new request when the register is free or being taken this cycle.
    assign q_pop     = !q_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= q_data;
    end

endmodule

>>> rtl/csv_line_field_splitter.sv
// Top level of the CSV line field splitter.
//
// Input channel (in_valid/in_ready): one request per byte of a CSV line in
// char_in, or an end-of-line marker with is_end high. Output channel
// (out_valid/out_ready): exactly one result per input request, in order,
// carrying a content byte, a field end, a line end and a truncation flag.
// The field limit is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, and the block itself leaves this unchecked.
// Throughput is one request per cycle while the queue has room: the parser
// updates its quoting mode and field count as each byte is accepted, so
// bytes can follow back to back. An accepted request's result is written
// into the queue and from there into the output register.
// A four-entry queue separates the parser from the output register, so the
// input keeps flowing while a result waits; in_ready drops only when the
// queue is full because the receiver has stalled.
// Reset clears the queue and output register, returns quoting to unquoted,
// the field count to zero, and the field limit to 128.
module csv_line_field_splitter #(
    parameter int unsigned MAX_COLUMNS = csvs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [7:0]                 cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 char_in,
    input  logic                       is_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 data_byte,
    output logic                       data_valid,
    output logic                       field_end,
    output logic [csvs_pkg::IDX_W-1:0] field_index,
    output logic                       line_end,
    output logic                       truncated
);

    logic           q_full;
    logic           q_push;
    logic           q_empty;
    logic           q_pop;
    csvs_pkg::res_t q_in;
    csvs_pkg::res_t q_out;
    csvs_pkg::res_t out_res;

    // Parser front end.
    csvs_front #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .is_end     (is_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    // Result queue.
    csvs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_data (q_out)
    );

    // Output register stage.
    csvs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_res  (out_res)
    );

    // Unpack the result onto the field ports.
    assign data_byte   = out_res.data_byte;
    assign data_valid  = out_res.data_valid;
    assign field_end   = out_res.field_end;
    assign field_index = out_res.field_index;
    assign line_end    = out_res.line_end;
    assign truncated   = out_res.truncated;

endmodule

>>> tb/sv/tb_csv_line_field_splitter.sv
// Self-checking testbench for the CSV line field splitter: directed and random lines.
module tb_csv_line_field_splitter;

    localparam int unsigned COLUMNS = csvs_pkg::MAX_COLUMNS_DEF;
    localparam int PHASE_ITEMS = 200;

    // Quoting modes of the field parser.
    typedef enum logic [1:0] {
        MODE_UNQUOTED,
        MODE_QUOTED,
        MODE_QUOTE_SEEN
    } quote_mode_e;

    // Tracks the parser state, predicts one result per request and checks results in order.
    class splitter_scoreboard;
        quote_mode_e    mode;
        bit             at_start;
        logic [8:0]     open_field;
        logic [7:0]     limit_cfg;
        csvs_pkg::res_t expected_q[$];
        int             mismatches;

        function new();
            mode       = MODE_UNQUOTED;
            at_start   = 1'b1;
            open_field = '0;
            limit_cfg  = csvs_pkg::LIMIT_CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_limit_cfg(logic [7:0] value);
            limit_cfg = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A limit of zero acts as one; anything above the column capacity is clipped.
        function logic [8:0] field_limit();
            logic [8:0] lim;
            lim = {1'b0, limit_cfg};
            if (lim == 9'd0)
                lim = 9'd1;
            if (lim > 9'(COLUMNS))
                lim = 9'(COLUMNS);
            return lim;
        endfunction

        // Works out the result of one accepted request and advances the parser state.
        function void note_request(logic [7:0] c, logic line_done);
            csvs_pkg::res_t r;
            logic [8:0]     lim;
            r   = '0;
            lim = field_limit();
            if (line_done)
            begin
                r.line_end = 1'b1;
                if (open_field < lim)
                begin
                    r.field_end   = 1'b1;
                    r.field_index = open_field[csvs_pkg::IDX_W-1:0];
                end
                else
                    r.truncated = 1'b1;
                mode       = MODE_UNQUOTED;
                at_start   = 1'b1;
                open_field = '0;
            end
            else if (c == csvs_pkg::CH_CR || c == csvs_pkg::CH_LF)
            begin
                // Line terminators vanish without touching the state.
            end
            else if (open_field >= lim)
                r.truncated = 1'b1;
            else if (mode == MODE_QUOTED)
            begin
                if (c == csvs_pkg::CH_QUOTE)
                    mode = MODE_QUOTE_SEEN;
                else
                begin
                    at_start      = 1'b0;
                    r.data_byte   = c;
                    r.data_valid  = 1'b1;
                    r.field_index = open_field[csvs_pkg::IDX_W-1:0];
                end
            end
            else if (mode == MODE_QUOTE_SEEN && c == csvs_pkg::CH_QUOTE)
            begin
                // A doubled quote inside quotes yields one literal quote.
                mode          = MODE_QUOTED;
                at_start      = 1'b0;
                r.data_byte   = csvs_pkg::CH_QUOTE;
                r.data_valid  = 1'b1;
                r.field_index = open_field[csvs_pkg::IDX_W-1:0];
            end
            else
            begin
                // Unquoted handling; a pending closing quote is simply dropped.
                mode = MODE_UNQUOTED;
                if (c == csvs_pkg::CH_QUOTE)
                begin
                    mode = MODE_QUOTED;
                    if (at_start)
                        at_start = 1'b0;
                    else
                    begin
                        r.data_byte   = csvs_pkg::CH_QUOTE;
                        r.data_valid  = 1'b1;
                        r.field_index = open_field[csvs_pkg::IDX_W-1:0];
                    end
                end
                else if (c == csvs_pkg::CH_COMMA)
                begin
                    r.field_end   = 1'b1;
                    r.field_index = open_field[csvs_pkg::IDX_W-1:0];
                    open_field    = open_field + 9'd1;
                    at_start      = 1'b1;
                end
                else
                begin
                    at_start      = 1'b0;
                    r.data_byte   = c;
                    r.data_valid  = 1'b1;
                    r.field_index = open_field[csvs_pkg::IDX_W-1:0];
                end
            end
            expected_q.push_back(r);
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(csvs_pkg::res_t got);
            csvs_pkg::res_t exp;
            bit             bad;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request pending: %p", $realtime, got);
                return;
            end
            exp = expected_q.pop_front();
            bad = (got.data_byte !== exp.data_byte) || (got.data_valid !== exp.data_valid)
                || (got.field_end !== exp.field_end) || (got.field_index !== exp.field_index)
                || (got.line_end !== exp.line_end) || (got.truncated !== exp.truncated);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected byte=%h dv=%b fend=%b idx=%0d lend=%b trunc=%b",
                             exp.data_byte, exp.data_valid, exp.field_end,
                             exp.field_index, exp.line_end, exp.truncated);
                    $display("  actual   byte=%h dv=%b fend=%b idx=%0d lend=%b trunc=%b",
                             got.data_byte, got.data_valid, got.field_end,
                             got.field_index, got.line_end, got.truncated);
                end
            end
        endfunction

        // Predictions that never got a result count as failures.
        function void flush_leftover();
            if (expected_q.size() != 0)
            begin
                $display("%0d expected results never arrived", expected_q.size());
                mismatches += expected_q.size();
                expected_q.delete();
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [7:0]                 cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 char_in = '0;
    logic                       is_end = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [7:0]                 data_byte;
    logic                       data_valid;
    logic                       field_end;
    logic [csvs_pkg::IDX_W-1:0] field_index;
    logic                       line_end;
    logic                       truncated;

    splitter_scoreboard sb = new();

    int unsigned items_sent = 0;
    bit          eager = 1'b0;
    bit          long_hold_req = 1'b0;
    int          stall_left = 0;
    int          ready_left = 0;

    csv_line_field_splitter #(
        .MAX_COLUMNS(COLUMNS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .is_end     (is_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .field_end  (field_end),
        .field_index(field_index),
        .line_end   (line_end),
        .truncated  (truncated)
    );

    // Clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Printable byte that is neither a quote nor a comma.
    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == csvs_pkg::CH_QUOTE || c == csvs_pkg::CH_COMMA)
            c = 8'h2D;
        return c;
    endfunction

    function automatic logic [7:0] pick_terminator();
        return $urandom_range(0, 1) ? csvs_pkg::CH_CR : csvs_pkg::CH_LF;
    endfunction

    // Watch both channels at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(char_in, is_end);
            if (out_valid && out_ready)
                sb.check_result({data_byte, data_valid, field_end, field_index,
                                 line_end, truncated});
        end
    end

    // Receiver: random stalls, quiet stretches, and a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = 64;
                ready_left    = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (ready_left > 0)
            begin
                out_ready <= 1'b1;
                ready_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                ready_left = ($urandom_range(0, 9) == 0) ? 50 : $urandom_range(0, 6);
                stall_left = pick_gap();
            end
        end
    end

    // Offer one request, hold it until accepted, then maybe idle.
    task automatic send_item(input logic [7:0] c, input logic line_done);
        int gap;
        in_valid <= 1'b1;
        char_in  <= c;
        is_end   <= line_done;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        gap = eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            char_in  <= 8'($urandom);
            is_end   <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every predicted result has been checked.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit_cfg(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_limit_cfg(value);
    endtask

    // Unquoted field content, sometimes with stray quotes and terminators.
    task automatic send_plain_field();
        int r;
        repeat ($urandom_range(0, 5))
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_item(pick_text(), 1'b0);
            else if (r < 82)
                send_item(8'($urandom), 1'b0);
            else if (r < 90)
                send_item(pick_terminator(), 1'b0);
            else
                send_item(csvs_pkg::CH_QUOTE, 1'b0);
        end
    endtask

    // Quoted field with commas and doubled quotes inside; sometimes left open.
    task automatic send_quoted_field();
        int r;
        send_item(csvs_pkg::CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 5))
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_item(pick_text(), 1'b0);
            else if (r < 65)
                send_item(csvs_pkg::CH_COMMA, 1'b0);
            else if (r < 78)
            begin
                send_item(csvs_pkg::CH_QUOTE, 1'b0);
                send_item(csvs_pkg::CH_QUOTE, 1'b0);
            end
            else if (r < 86)
                send_item(pick_terminator(), 1'b0);
            else
                send_item(8'($urandom), 1'b0);
        end
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            send_item(csvs_pkg::CH_QUOTE, 1'b0);
            if (r < 17)
                send_item(pick_text(), 1'b0);
        end
    endtask

    // One line: mostly well formed, sometimes noise, now and then without an end.
    task automatic send_random_line();
        int nfields;
        int r;
        nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 12))
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    send_item(csvs_pkg::CH_QUOTE, 1'b0);
                else if (r < 50)
                    send_item(csvs_pkg::CH_COMMA, 1'b0);
                else if (r < 60)
                    send_item(pick_terminator(), 1'b0);
                else
                    send_item(8'($urandom), 1'b0);
            end
        end
        else
        begin
            for (int f = 0; f < nfields; f++)
            begin
                if (f > 0)
                    send_item(csvs_pkg::CH_COMMA, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_quoted_field();
                else
                    send_plain_field();
            end
        end
        if ($urandom_range(0, 99) < 95)
            send_item(8'($urandom), 1'b1);
    endtask

    // A line with more fields than the column capacity.
    task automatic send_wide_line();
        for (int f = 0; f < int'(COLUMNS) + 6; f++)
        begin
            send_item(pick_text(), 1'b0);
            send_item(csvs_pkg::CH_COMMA, 1'b0);
        end
        send_item(8'($urandom), 1'b1);
    endtask

    // Watchdog.
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [7:0]  limits[8];
        int unsigned phase_start;
        limits = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd3, 8'd128, 8'd5, 8'd0};
        limits[7] = 8'($urandom_range(1, 255));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines at the reset limit.
        send_item(8'($urandom), 1'b1);              // empty line
        send_item(8'h00, 1'b0);
        send_item(csvs_pkg::CH_COMMA, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h55, 1'b1);
        send_item(csvs_pkg::CH_QUOTE, 1'b0);        // quoted field with doubled quote
        send_item(8'h78, 1'b0);
        send_item(csvs_pkg::CH_QUOTE, 1'b0);
        send_item(csvs_pkg::CH_QUOTE, 1'b0);
        send_item(csvs_pkg::CH_COMMA, 1'b0);
        send_item(csvs_pkg::CH_QUOTE, 1'b0);        // closing quote then a comma
        send_item(csvs_pkg::CH_COMMA, 1'b0);
        send_item(8'h61, 1'b0);                     // quote inside unquoted field
        send_item(csvs_pkg::CH_QUOTE, 1'b0);
        send_item(csvs_pkg::CH_CR, 1'b0);
        send_item(csvs_pkg::CH_LF, 1'b0);
        send_item(8'hAA, 1'b1);                     // end of line inside quotes
        send_item(csvs_pkg::CH_QUOTE, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(csvs_pkg::CH_QUOTE, 1'b0);
        send_item(8'h00, 1'b1);                     // end with a pending quote

        // Random phases, each at its own field limit.
        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            write_limit_cfg(limits[p]);
            phase_start = items_sent;
            if (limits[p] == 8'd255)
            begin
                // Receiver holds off while the sender streams without gaps.
                eager = 1'b1;
                long_hold_req = 1'b1;
                repeat (40) send_item(pick_text(), 1'b0);
                send_item(8'($urandom), 1'b1);
                eager = 1'b0;
            end
            if (limits[p] == 8'd255 || limits[p] == 8'd128)
                send_wide_line();
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                eager = ($urandom_range(0, 4) == 0);
                send_random_line();
            end
            eager = 1'b0;
        end

        drain_results();
        repeat (10) @(posedge clk);
        sb.flush_leftover();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
